[hw/rtl/oata_pkg.sv]
package oata_pkg;

  localparam int unsigned CoordW = 13;
  localparam int unsigned BoxW   = 12;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned MaxCmd = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned SlotW  = 2;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;
  localparam int unsigned InW    = 32;
  localparam int unsigned OutW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CmdW-1:0] CMD_STOP       = 4'd0;
  localparam logic [CmdW-1:0] CMD_FORWARD    = 4'd1;
  localparam logic [CmdW-1:0] CMD_BACK       = 4'd2;
  localparam logic [CmdW-1:0] CMD_TURN_LEFT  = 4'd3;
  localparam logic [CmdW-1:0] CMD_TURN_RIGHT = 4'd4;
  localparam logic [CmdW-1:0] CMD_LOOK_LEFT  = 4'd5;
  localparam logic [CmdW-1:0] CMD_LOOK_RIGHT = 4'd6;
  localparam logic [CmdW-1:0] CMD_LOOK_UP    = 4'd7;
  localparam logic [CmdW-1:0] CMD_LOOK_DOWN  = 4'd8;
  localparam logic [CmdW-1:0] CMD_FIRE       = 4'd9;
  localparam logic [CmdW-1:0] CMD_CEASE      = 4'd10;
  localparam logic [CmdW-1:0] CMD_CENTER     = 4'd11;

  localparam logic [1:0] MODE_SEARCH  = 2'd0;
  localparam logic [1:0] MODE_AVOID_L = 2'd1;
  localparam logic [1:0] MODE_AVOID_R = 2'd2;
  localparam logic [1:0] MODE_TARGET  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_BOX_LEFT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BOX_TOP    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BOX_WIDTH  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_BOX_HEIGHT = 2'd3;

  localparam logic [BoxW-1:0] BOX_LEFT_RST   = 12'd195;
  localparam logic [BoxW-1:0] BOX_TOP_RST    = 12'd115;
  localparam logic [BoxW-1:0] BOX_WIDTH_RST  = 12'd250;
  localparam logic [BoxW-1:0] BOX_HEIGHT_RST = 12'd250;

  typedef struct packed {
    logic [CntW-1:0]              count;
    logic [MaxCmd-1:0][CmdW-1:0]  cmd;
  } ops_t;

  typedef struct packed {
    logic [BoxW-1:0] left;
    logic [BoxW-1:0] top;
    logic [BoxW-1:0] width;
    logic [BoxW-1:0] height;
  } box_t;

endpackage

[hw/rtl/oata_front.sv]
module oata_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [oata_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [oata_pkg::BoxW-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [oata_pkg::InW-1:0]     s_tdata,
  input  logic                 q_full,
  output logic                 q_push,
  output oata_pkg::ops_t       q_data
);
  import oata_pkg::*;

  box_t       box;
  logic [1:0] mode;
  logic [1:0] mode_next;
  logic       started;
  logic       accept;

  logic                     lb, rb, fb;
  logic signed [CoordW:0]   x, y, xl, xr, yt, yb;
  logic                     x_none, y_none;
  ops_t                     ops;

  assign lb = s_tdata[0];
  assign rb = s_tdata[1];
  assign fb = s_tdata[2];
  assign x  = {s_tdata[15], s_tdata[15:3]};
  assign y  = {s_tdata[28], s_tdata[28:16]};
  assign x_none = (s_tdata[15:3] == '1);
  assign y_none = (s_tdata[28:16] == '1);

  assign xl = {2'b00, box.left};
  assign yt = {2'b00, box.top};
  assign xr = {1'b0, ({1'b0, box.left} + {1'b0, box.width})};
  assign yb = {1'b0, ({1'b0, box.top} + {1'b0, box.height})};

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // command list for one tick
  always_comb begin
    logic xon;
    logic yon;
    ops       = '0;
    mode_next = mode;
    xon       = 1'b0;
    yon       = 1'b0;
    if (!started) begin
      ops.cmd[ops.count[SlotW-1:0]] = CMD_FORWARD;
      ops.count = ops.count + 3'd1;
    end
    case (mode)
      MODE_SEARCH: begin
        if (fb) begin
          ops.cmd[ops.count[SlotW-1:0]] = CMD_STOP;
          ops.count = ops.count + 3'd1;
          if (!lb) begin
            ops.cmd[ops.count[SlotW-1:0]] = CMD_TURN_LEFT;
            ops.count = ops.count + 3'd1;
            mode_next = MODE_AVOID_L;
          end else if (!rb) begin
            ops.cmd[ops.count[SlotW-1:0]] = CMD_TURN_RIGHT;
            ops.count = ops.count + 3'd1;
            mode_next = MODE_AVOID_R;
          end
        end else if (rb) begin
          ops.cmd[ops.count[SlotW-1:0]] = CMD_TURN_LEFT;
          ops.count = ops.count + 3'd1;
          mode_next = MODE_AVOID_L;
        end else if (lb) begin
          ops.cmd[ops.count[SlotW-1:0]] = CMD_TURN_RIGHT;
          ops.count = ops.count + 3'd1;
          mode_next = MODE_AVOID_R;
        end
        if (!x_none && !y_none) begin
          ops.cmd[ops.count[SlotW-1:0]] = CMD_STOP;
          ops.count = ops.count + 3'd1;
          mode_next = MODE_TARGET;
        end
      end
      MODE_AVOID_L, MODE_AVOID_R: begin
        if ((mode == MODE_AVOID_L) ? (!rb && !fb) : (!lb && !fb)) begin
          ops.cmd[ops.count[SlotW-1:0]] = CMD_CENTER;
          ops.count = ops.count + 3'd1;
          ops.cmd[ops.count[SlotW-1:0]] = CMD_FORWARD;
          ops.count = ops.count + 3'd1;
          mode_next = MODE_SEARCH;
        end
      end
      default: begin
        if (x_none && y_none) begin
          ops.cmd[ops.count[SlotW-1:0]] = CMD_CENTER;
          ops.count = ops.count + 3'd1;
          ops.cmd[ops.count[SlotW-1:0]] = CMD_CEASE;
          ops.count = ops.count + 3'd1;
          ops.cmd[ops.count[SlotW-1:0]] = CMD_FORWARD;
          ops.count = ops.count + 3'd1;
          mode_next = MODE_SEARCH;
        end else begin
          if (x < xl) begin
            ops.cmd[ops.count[SlotW-1:0]] = CMD_LOOK_LEFT;
            ops.count = ops.count + 3'd1;
          end else if (x > xr) begin
            ops.cmd[ops.count[SlotW-1:0]] = CMD_LOOK_RIGHT;
            ops.count = ops.count + 3'd1;
          end else begin
            xon = 1'b1;
          end
          if (y < yt) begin
            ops.cmd[ops.count[SlotW-1:0]] = CMD_LOOK_UP;
            ops.count = ops.count + 3'd1;
          end else if (y > yb) begin
            ops.cmd[ops.count[SlotW-1:0]] = CMD_LOOK_DOWN;
            ops.count = ops.count + 3'd1;
          end else begin
            yon = 1'b1;
          end
          ops.cmd[ops.count[SlotW-1:0]] = (xon && yon) ? CMD_FIRE : CMD_CEASE;
          ops.count = ops.count + 3'd1;
        end
      end
    endcase
  end

  assign q_push = accept && (ops.count != '0);
  assign q_data = ops;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_SEARCH;
      started <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      started <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box.left   <= BOX_LEFT_RST;
      box.top    <= BOX_TOP_RST;
      box.width  <= BOX_WIDTH_RST;
      box.height <= BOX_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_LEFT:   box.left   <= cfg_data;
        REG_BOX_TOP:    box.top    <= cfg_data;
        REG_BOX_WIDTH:  box.width  <= cfg_data;
        REG_BOX_HEIGHT: box.height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/oata_queue.sv]
module oata_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  oata_pkg::ops_t push_data,
  output logic           full,
  input  logic           pop,
  output oata_pkg::ops_t pop_data,
  output logic           empty
);
  import oata_pkg::*;

  ops_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QDepth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/oata_back.sv]
module oata_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  oata_pkg::ops_t            q_data,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [oata_pkg::OutW-1:0] m_tdata,
  output logic                      m_tlast
);
  import oata_pkg::*;

  ops_t             cur;
  logic             cur_valid;
  logic [SlotW-1:0] idx;
  logic             cur_last;
  logic             out_ld;

  assign cur_last = ({1'b0, idx} == (cur.count - 3'd1));
  assign out_ld   = cur_valid && (!m_tvalid || m_tready);
  assign q_pop    = !q_empty && (!cur_valid || (out_ld && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (out_ld) begin
      cur_valid <= !cur_last;
      idx       <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      m_tdata <= {{(OutW-CmdW){1'b0}}, cur.cmd[idx]};
      m_tlast <= cur_last;
    end
  end

endmodule

[hw/rtl/obstacle_avoid_target_aim_fsm_unit.sv]
// obstacle avoiding, target aiming controller
// s_t* carries one control tick per transfer: sensor bits and target position
// m_t* carries the resulting motion, camera and laser commands, one per
// transfer, with m_tlast on the final command of each tick; a tick that
// produces no command gives no transfer at all
// cfg_we / cfg_index / cfg_data write the aim box registers (left, top, width,
// height); user must write only while the block is idle (not enforced)
// a tick's 1 to 4 commands pass through a queue slot, the back end's
// current-tick register and the single output register, which issues one
// command per cycle while the receiver is ready; quiet and single-command
// ticks go at one per cycle unless the receiver stalls
// a two-entry queue sits between the classifying front end and the issuing
// back end, so input keeps flowing while a stalled receiver holds results
// s_tready drops only when that queue is full
// reset clears mode to searching, re-arms the start command (forward, sent
// ahead of the first tick's commands) and restores the default aim box
// a stalled receiver holds m_tvalid, m_tdata and m_tlast steady
module obstacle_avoid_target_aim_fsm_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [oata_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [oata_pkg::BoxW-1:0]    cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // left_blocked, right_blocked, front_blocked, target_x[12:0], target_y[12:0]
  input  logic [oata_pkg::InW-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // command[3:0]
  output logic [oata_pkg::OutW-1:0]    m_tdata,
  output logic                         m_tlast
);
  import oata_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  ops_t q_in;
  ops_t q_out;

  oata_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  oata_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  oata_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

[hw/rtl/oata_checker.sv]
module oata_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [oata_pkg::OutW-1:0] m_tdata,
  input logic                      m_tlast
);
  import oata_pkg::*;

  // empty queue and output stage after reset
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("not idle after reset");

  // stalled transfer holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed while stalled");

  // fire always closes a run
  a_fire_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[CmdW-1:0] == CMD_FIRE)) |-> m_tlast)
    else $error("fire not last of run");

  // unused pad bits stay zero and the command code is at most CMD_CENTER
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[OutW-1:CmdW] == '0) && (m_tdata[CmdW-1:0] <= CMD_CENTER)))
    else $error("bad command code");

endmodule

bind obstacle_avoid_target_aim_fsm_unit oata_checker u_oata_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

[test/testbench.sv]
module testbench;
  import oata_pkg::*;

  localparam int PREDICT = -1;
  localparam int RAND_PER_PHASE = 43;
  localparam int NUM_PHASES = 6;
  localparam logic signed [CoordW-1:0] NO_TARGET = -13'sd1;
  localparam logic [0:MaxCmd-1][CmdW-1:0] NO_CMDS = '0;

  typedef struct packed {
    logic                          lb;
    logic                          rb;
    logic                          fb;
    logic signed [CoordW-1:0]      x;
    logic signed [CoordW-1:0]      y;
    int                            typed_n;
    logic [0:MaxCmd-1][CmdW-1:0]   typed_cmds;
  } tick_row_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            last;
  } cmd_exp_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CfgIdxW-1:0]    cfg_index;
  logic [BoxW-1:0]       cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [InW-1:0]        s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OutW-1:0]       m_tdata;
  logic                  m_tlast;

  obstacle_avoid_target_aim_fsm_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // predictor state
  logic [1:0]      ctl_mode;
  logic            start_sent;
  logic [BoxW-1:0] aim_left, aim_top, aim_width, aim_height;

  cmd_exp_t cmd_expected [$];
  cmd_exp_t exp_c;
  int       mismatches = 0;
  int       ticks_sent = 0;
  int       cmds_checked = 0;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;

  tick_row_t dir_tab [25] = '{
    '{1'b0, 1'b0, 1'b1, 13'sd0, 13'sd0, 4,
      {CMD_FORWARD, CMD_STOP, CMD_TURN_LEFT, CMD_STOP}},
    '{1'b0, 1'b0, 1'b0, 13'sd0, 13'sd0, PREDICT, NO_CMDS},
    '{1'b1, 1'b1, 1'b1, 13'sd4095, 13'sd4095, 3,
      {CMD_LOOK_RIGHT, CMD_LOOK_DOWN, CMD_CEASE, CMD_STOP}},
    '{1'b0, 1'b0, 1'b0, -13'sd4096, -13'sd4096, PREDICT, NO_CMDS},
    '{1'b0, 1'b1, 1'b0, 13'sd195, 13'sd115, 1,
      {CMD_FIRE, CMD_STOP, CMD_STOP, CMD_STOP}},
    '{1'b0, 1'b0, 1'b0, 13'sd445, 13'sd365, PREDICT, NO_CMDS},
    '{1'b0, 1'b0, 1'b0, 13'sd446, 13'sd366, PREDICT, NO_CMDS},
    '{1'b0, 1'b0, 1'b0, NO_TARGET, 13'sd300, PREDICT, NO_CMDS},
    '{1'b0, 1'b0, 1'b0, 13'sd300, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b1, 1'b0, 1'b1, NO_TARGET, NO_TARGET, 3,
      {CMD_CENTER, CMD_CEASE, CMD_FORWARD, CMD_STOP}},
    '{1'b0, 1'b0, 1'b0, NO_TARGET, NO_TARGET, 0, NO_CMDS},
    '{1'b0, 1'b1, 1'b0, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b0, 1'b1, 1'b0, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b1, 1'b0, 1'b1, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b1, 1'b0, 1'b0, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b1, 1'b0, 1'b0, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b1, 1'b0, 1'b0, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b0, 1'b1, 1'b1, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b0, 1'b1, 1'b0, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b1, 1'b0, 1'b1, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS},
    '{1'b0, 1'b0, 1'b0, 13'sd100, 13'sd100, PREDICT, NO_CMDS},
    '{1'b1, 1'b1, 1'b1, NO_TARGET, NO_TARGET, 1,
      {CMD_STOP, CMD_STOP, CMD_STOP, CMD_STOP}},
    '{1'b0, 1'b0, 1'b0, NO_TARGET, 13'sd50, PREDICT, NO_CMDS},
    '{1'b0, 1'b0, 1'b0, -13'sd2, 13'sd4095, PREDICT, NO_CMDS},
    '{1'b0, 1'b0, 1'b0, NO_TARGET, NO_TARGET, PREDICT, NO_CMDS}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // commands for one control tick, advancing the mode and start flag
  function automatic int plan_tick(input logic lb, input logic rb, input logic fb,
                                   input logic signed [CoordW-1:0] x,
                                   input logic signed [CoordW-1:0] y,
                                   output logic [CmdW-1:0] cmds [MaxCmd]);
    int   n;
    int   xi, yi, xr, yb;
    logic xon, yon;
    n = 0;
    xi = x;
    yi = y;
    xon = 1'b0;
    yon = 1'b0;
    xr = int'(aim_left) + int'(aim_width);
    yb = int'(aim_top) + int'(aim_height);
    cmds = '{default: CMD_STOP};
    if (!start_sent) begin
      cmds[n] = CMD_FORWARD; n++;
      start_sent = 1'b1;
    end
    case (ctl_mode)
      MODE_SEARCH: begin
        if (fb) begin
          cmds[n] = CMD_STOP; n++;
          if (!lb) begin
            cmds[n] = CMD_TURN_LEFT; n++;
            ctl_mode = MODE_AVOID_L;
          end else if (!rb) begin
            cmds[n] = CMD_TURN_RIGHT; n++;
            ctl_mode = MODE_AVOID_R;
          end
        end else if (rb) begin
          cmds[n] = CMD_TURN_LEFT; n++;
          ctl_mode = MODE_AVOID_L;
        end else if (lb) begin
          cmds[n] = CMD_TURN_RIGHT; n++;
          ctl_mode = MODE_AVOID_R;
        end
        if (xi != -1 && yi != -1) begin
          cmds[n] = CMD_STOP; n++;
          ctl_mode = MODE_TARGET;
        end
      end
      MODE_AVOID_L: begin
        if (!rb && !fb) begin
          cmds[n] = CMD_CENTER; n++;
          cmds[n] = CMD_FORWARD; n++;
          ctl_mode = MODE_SEARCH;
        end
      end
      MODE_AVOID_R: begin
        if (!lb && !fb) begin
          cmds[n] = CMD_CENTER; n++;
          cmds[n] = CMD_FORWARD; n++;
          ctl_mode = MODE_SEARCH;
        end
      end
      default: begin
        if (xi == -1 && yi == -1) begin
          cmds[n] = CMD_CENTER; n++;
          cmds[n] = CMD_CEASE; n++;
          cmds[n] = CMD_FORWARD; n++;
          ctl_mode = MODE_SEARCH;
        end else begin
          if (xi < int'(aim_left)) begin
            cmds[n] = CMD_LOOK_LEFT; n++;
          end else if (xi > xr) begin
            cmds[n] = CMD_LOOK_RIGHT; n++;
          end else begin
            xon = 1'b1;
          end
          if (yi < int'(aim_top)) begin
            cmds[n] = CMD_LOOK_UP; n++;
          end else if (yi > yb) begin
            cmds[n] = CMD_LOOK_DOWN; n++;
          end else begin
            yon = 1'b1;
          end
          cmds[n] = (xon && yon) ? CMD_FIRE : CMD_CEASE; n++;
        end
      end
    endcase
    return n;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord(input int lo, input int hi);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 8191);
      1: v = lo - 1 + $urandom_range(0, 2);
      2: v = hi - 1 + $urandom_range(0, 2);
      default: v = lo + $urandom_range(0, hi - lo);
    endcase
    return v[CoordW-1:0];
  endfunction

  // called just after a falling edge, returns just after one
  task automatic send_tick(input logic lb, input logic rb, input logic fb,
                           input logic signed [CoordW-1:0] x,
                           input logic signed [CoordW-1:0] y,
                           input int typed_n,
                           input logic [0:MaxCmd-1][CmdW-1:0] typed_cmds);
    logic [CmdW-1:0] cmds [MaxCmd];
    int              n;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, y, x, fb, rb, lb};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    n = plan_tick(lb, rb, fb, x, y, cmds);
    if (typed_n != PREDICT) begin
      n = typed_n;
      for (int i = 0; i < MaxCmd; i++) cmds[i] = typed_cmds[i];
    end
    for (int i = 0; i < n; i++) cmd_expected.push_back('{cmds[i], i == n - 1});
    @(negedge clk);
  endtask

  task automatic set_box(input logic [BoxW-1:0] l, input logic [BoxW-1:0] t,
                         input logic [BoxW-1:0] w, input logic [BoxW-1:0] h);
    logic [BoxW-1:0]    vals [4];
    logic [CfgIdxW-1:0] idxs [4];
    vals = '{l, t, w, h};
    idxs = '{REG_BOX_LEFT, REG_BOX_TOP, REG_BOX_WIDTH, REG_BOX_HEIGHT};
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[r];
      cfg_data  <= vals[r];
      @(negedge clk);
    end
    cfg_we     <= 1'b0;
    aim_left   = l;
    aim_top    = t;
    aim_width  = w;
    aim_height = h;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (cmd_expected.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cmd_expected.size() == 0) begin
        $display("%0t: command transfer with none expected, actual cmd %0d last %0b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        exp_c = cmd_expected.pop_front();
        cmds_checked++;
        if (m_tdata != {{(OutW - CmdW){1'b0}}, exp_c.cmd} || m_tlast != exp_c.last) begin
          $display("%0t: expected cmd %0d last %0b, actual cmd %0d last %0b",
                   $time, exp_c.cmd, exp_c.last, m_tdata, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic                     lb, rb, fb;
    logic signed [CoordW-1:0] x, y;
    int                       k;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    ctl_mode   = MODE_SEARCH;
    start_sent = 1'b0;
    aim_left   = BOX_LEFT_RST;
    aim_top    = BOX_TOP_RST;
    aim_width  = BOX_WIDTH_RST;
    aim_height = BOX_HEIGHT_RST;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i])
      send_tick(dir_tab[i].lb, dir_tab[i].rb, dir_tab[i].fb, dir_tab[i].x, dir_tab[i].y,
                dir_tab[i].typed_n, dir_tab[i].typed_cmds);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_box('0, '0, '0, '0);
        1: set_box('1, '1, '1, '1);
        2: set_box(BOX_LEFT_RST, BOX_TOP_RST, BOX_WIDTH_RST, BOX_HEIGHT_RST);
        3: set_box(BoxW'($urandom), BoxW'($urandom), BoxW'($urandom), BoxW'($urandom));
        4: set_box('1, '0, '0, '1);
        default: set_box(BoxW'($urandom), BoxW'($urandom),
                         BoxW'($urandom_range(0, 20)), BoxW'($urandom_range(0, 20)));
      endcase
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
        default: begin send_gap_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        lb = 1'($urandom_range(0, 1));
        rb = 1'($urandom_range(0, 1));
        fb = 1'($urandom_range(0, 1));
        k  = $urandom_range(0, 9);
        if (k < 3) begin
          x = NO_TARGET;
          y = NO_TARGET;
        end else begin
          x = rand_coord(int'(aim_left), int'(aim_left) + int'(aim_width));
          y = rand_coord(int'(aim_top), int'(aim_top) + int'(aim_height));
          if (k == 3) begin
            if ($urandom_range(0, 1)) x = NO_TARGET;
            else y = NO_TARGET;
          end
        end
        send_tick(lb, rb, fb, x, y, PREDICT, NO_CMDS);
      end
      drain();
    end

    $display("run covered %0d control ticks (directed then random) over %0d aim box settings",
             ticks_sent, NUM_PHASES + 1);
    $display("with four idling patterns on both sides; %0d command transfers checked",
             cmds_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
